[hdl/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/wdtq_pkg.sv]
// Types and constants for the wrapping deadline task queue.
// No dependencies; the top level, dtq_scan and the testbench import this package.
package wdtq_pkg;

	localparam int DL_BITS  = 32;
	localparam int TAG_W    = 16;

	typedef enum logic [1:0] {
		CMD_SCHED       = 2'd0,
		CMD_RESCHED     = 2'd1,
		CMD_DISP_FIRST  = 2'd2,
		CMD_DISP_NEXT   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_TOO_FAR  = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESCAN
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic [DL_BITS-1:0] delay_ticks;
		logic [TAG_W-1:0]   task_tag;
		logic [DL_BITS-1:0] now_count;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic               task_valid;
		logic [TAG_W-1:0]   dispatched_tag;
		logic               more_due;
		logic [DL_BITS-1:0] match_value;
	} out_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} scan_ctl_t;

	// x in [lo, hi) on a wrapping count
	function automatic logic in_window(logic [DL_BITS-1:0] lo, logic [DL_BITS-1:0] x,
		logic [DL_BITS-1:0] hi);
		if (lo < hi) begin
			return (x >= lo) && (x < hi);
		end
		return (x >= lo) || (x < hi);
	endfunction

endpackage

[hdl/wrapping_deadline_task_queue_top.sv]
// Top level of the wrapping deadline task queue: sequencer, entry RAM, scan unit.
// Depends on wdtq_pkg, assert_macros.svh, dtq_ram and dtq_scan.
//
//   channel | signals                       | direction
//   --------+-------------------------------+----------
//   command | start, busy, req (in_t)       | in
//   result  | done, rsp (out_t)             | out
//   config  | cfg_valid, cfg_ready, cfg_data| in
//
// A failed command (too far, full, empty) gives its result in the cycle
// after it is taken. A schedule takes one scan of the entries through the
// registered RAM read port. A dispatch takes one scan, one shift of the
// later entries down by one slot and, if entries remain, one more scan,
// all through the single RAM read port.
// Reset clears occupancy, match and burst reference; entries need no clearing.
// busy stays high until the result strobe; results cannot be stalled.
`include "assert_macros.svh"

module wrapping_deadline_task_queue_top
	import wdtq_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_t                req,
	output logic               done,
	output out_t               rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [DL_BITS-1:0] cfg_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = DL_BITS + TAG_BITS;

	state_t              state_q, state_d;
	in_t                 req_q;
	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       cnt_q;
	logic [DL_BITS-1:0]  period_q;
	logic [DL_BITS-1:0]  match_q;
	logic [DL_BITS-1:0]  burst_q;
	logic [DL_BITS-1:0]  ref_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                done_q;
	out_t                out_q;
	logic                rd_vld_s1;
	logic [AW-1:0]       rd_idx_s1;

	logic                accept;
	logic                is_sched;
	logic                too_far;
	logic                full;
	logic [DL_BITS-1:0]  base;
	logic [DL_BITS-1:0]  sum;
	logic [DL_BITS-1:0]  new_dl;
	logic [DL_BITS-1:0]  disp_ref;
	logic                issue;
	logic                pass_done;
	logic                more;

	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [RW-1:0]       wr_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [RW-1:0]       rd_data;
	scan_ctl_t           scan_ctl;
	logic [AW-1:0]       best_idx;
	logic [DL_BITS-1:0]  best_dl;
	logic [TAG_BITS-1:0] best_tag;

	// Command decode on the item being offered
	assign accept   = start && !busy;
	assign is_sched = (req.command == CMD_SCHED) || (req.command == CMD_RESCHED);
	assign base     = (req.command == CMD_SCHED) ? req.now_count : match_q;
	assign too_far  = (req.delay_ticks > period_q) ||
	                  (({1'b0, req.delay_ticks} + {1'b0, burst_q}) > {1'b0, {DL_BITS{1'b1}}});
	assign full     = (occ_q == CW'(DEPTH));
	assign sum      = base + req.delay_ticks;
	// wrap once past the period
	assign new_dl   = (sum > period_q) ? (sum - period_q) : sum;
	// dispatch first opens a burst at the match time
	assign disp_ref = (req.command == CMD_DISP_FIRST) ? match_q : burst_q;

	// Read sweep: issue while the counter is below occupancy, then drain
	assign issue     = (cnt_q < occ_q);
	assign pass_done = !issue && !rd_vld_s1;
	assign more      = in_window(burst_q, best_dl, req_q.now_count);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_sched) begin
						if (!too_far && !full) state_d = S_SCAN;
					end else if (occ_q != '0) begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (pass_done) begin
					state_d = ((req_q.command == CMD_SCHED) || (req_q.command == CMD_RESCHED))
					          ? S_IDLE : S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (pass_done) state_d = (occ_q == CW'(1)) ? S_IDLE : S_RESCAN;
			end
			S_RESCAN: begin
				if (pass_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM and scan unit control
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = occ_q[AW-1:0];
		wr_data      = {new_dl, TAG_BITS'(req.task_tag)};
		rd_en        = 1'b0;
		rd_addr      = cnt_q[AW-1:0];
		scan_ctl.clr = 1'b0;
		scan_ctl.vld = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				scan_ctl.clr = accept;
				// append the new task behind the others
				wr_en        = accept && is_sched && !too_far && !full;
			end
			S_SCAN, S_RESCAN: begin
				rd_en        = issue;
				scan_ctl.vld = rd_vld_s1;
			end
			S_SHIFT: begin
				// move each later entry down one slot
				rd_en        = issue;
				wr_en        = rd_vld_s1;
				wr_addr      = rd_idx_s1 - AW'(1);
				wr_data      = rd_data;
				scan_ctl.clr = pass_done;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			cnt_q     <= '0;
			period_q  <= {DL_BITS{1'b1}};
			match_q   <= '0;
			burst_q   <= '0;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= 1'b0;
			rd_vld_s1 <= rd_en;
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			if (rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (is_sched) begin
							if (too_far || full) begin
								done_q <= 1'b1;
							end else begin
								occ_q <= occ_q + CW'(1);
							end
						end else if (occ_q == '0) begin
							done_q <= 1'b1;
						end else begin
							burst_q <= disp_ref;
						end
					end
				end
				S_SCAN: begin
					if (pass_done) begin
						if ((req_q.command == CMD_SCHED) || (req_q.command == CMD_RESCHED)) begin
							match_q <= best_dl;
							done_q  <= 1'b1;
						end else begin
							cnt_q <= CW'(best_idx) + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (pass_done) begin
						occ_q <= occ_q - CW'(1);
						cnt_q <= '0;
						if (occ_q == CW'(1)) begin
							// queue left empty: keep match, end burst
							burst_q <= '0;
							done_q  <= 1'b1;
						end
					end
				end
				S_RESCAN: begin
					if (pass_done) begin
						match_q <= best_dl;
						done_q  <= 1'b1;
						if (!more) burst_q <= '0;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Payload registers: latched item, scan reference, popped tag, result
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q <= req;
					ref_q <= is_sched ? base : disp_ref;
					if (is_sched && too_far) begin
						out_q <= '{status: STAT_TOO_FAR, task_valid: 1'b0, dispatched_tag: '0,
						           more_due: 1'b0, match_value: match_q};
					end else if (is_sched && full) begin
						out_q <= '{status: STAT_FULL, task_valid: 1'b0, dispatched_tag: '0,
						           more_due: 1'b0, match_value: match_q};
					end else begin
						out_q <= '{status: STAT_EMPTY, task_valid: 1'b0, dispatched_tag: '0,
						           more_due: 1'b0, match_value: match_q};
					end
				end
			end
			S_SCAN: begin
				if (pass_done) begin
					tag_q <= best_tag;
					out_q <= '{status: STAT_OK, task_valid: 1'b0, dispatched_tag: '0,
					           more_due: 1'b0, match_value: best_dl};
				end
			end
			S_SHIFT: begin
				if (pass_done) begin
					out_q <= '{status: STAT_OK, task_valid: 1'b1,
					           dispatched_tag: TAG_W'(tag_q), more_due: 1'b0,
					           match_value: match_q};
				end
			end
			S_RESCAN: begin
				if (pass_done) begin
					out_q <= '{status: STAT_OK, task_valid: 1'b1,
					           dispatched_tag: TAG_W'(tag_q), more_due: more,
					           match_value: best_dl};
				end
			end
			default: begin
				tag_q <= tag_q;
			end
		endcase
	end

	dtq_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_entries (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dtq_scan #(
		.AW       (AW),
		.TAG_BITS (TAG_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (scan_ctl),
		.ref_time      (ref_q),
		.period        (period_q),
		.idx           (rd_idx_s1),
		.deadline      (rd_data[RW-1:TAG_BITS]),
		.tag           (rd_data[TAG_BITS-1:0]),
		.best_idx      (best_idx),
		.best_deadline (best_dl),
		.best_tag      (best_tag)
	);

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign rsp       = out_q;
	assign cfg_ready = 1'b1;

	`ASSERT_NEVER(a_occ_bound, occ_q > CW'(DEPTH), "occupancy above depth")
	`ASSERT_CLK(a_accept_moves, accept |=> (busy || done), "accepted item neither busy nor done")
	`ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while still busy")
	`ASSERT_NEVER(a_read_idle, rd_vld_s1 && (state_q == S_IDLE), "RAM read data while idle")

endmodule

[hdl/dtq_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dtq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/dtq_scan.sv]
// Earliest-deadline tracker fed one entry per cycle from the entry RAM.
// Depends on wdtq_pkg.
module dtq_scan
	import wdtq_pkg::*;
#(
	parameter int AW       = 4,
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctl_t          ctl,
	input  logic [DL_BITS-1:0] ref_time,
	input  logic [DL_BITS-1:0] period,
	input  logic [AW-1:0]      idx,
	input  logic [DL_BITS-1:0] deadline,
	input  logic [TAG_BITS-1:0] tag,
	output logic [AW-1:0]      best_idx,
	output logic [DL_BITS-1:0] best_deadline,
	output logic [TAG_BITS-1:0] best_tag
);

	logic               have_q;
	logic [DL_BITS:0]   best_key_q;
	logic [AW-1:0]      best_idx_q;
	logic [DL_BITS-1:0] best_dl_q;
	logic [TAG_BITS-1:0] best_tag_q;
	logic [DL_BITS:0]   key;
	logic               take;

	// values below the reference count one period later
	assign key  = (deadline < ref_time) ? ({1'b0, deadline} + {1'b0, period})
	                                    : {1'b0, deadline};
	// strict compare keeps the oldest entry on a tie
	assign take = ctl.vld && (!have_q || (key < best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clr) begin
			have_q <= 1'b0;
		end else if (ctl.vld) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key;
			best_idx_q <= idx;
			best_dl_q  <= deadline;
			best_tag_q <= tag;
		end
	end

	assign best_idx      = best_idx_q;
	assign best_deadline = best_dl_q;
	assign best_tag      = best_tag_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the wrapping deadline task queue.
// Depends on wdtq_pkg and wrapping_deadline_task_queue_top; predicts each result in SV.
module testbench;
	import wdtq_pkg::*;

	localparam int DEPTH = 16;
	localparam int MAX_IDLE = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t req = '0;
	logic done;
	out_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [DL_BITS-1:0] cfg_data = '0;

	wrapping_deadline_task_queue_top #(.DEPTH(DEPTH), .TAG_BITS(TAG_W)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: a shadow of the queue contents and timing registers
	logic [31:0] sh_period;
	logic [31:0] sh_deadline[DEPTH];
	logic [15:0] sh_tag[DEPTH];
	int          sh_count;
	logic [31:0] sh_match;
	logic [31:0] sh_burst;

	out_t pending_results[$];
	int   mismatches = 0;
	int   idle_cycles = 0;
	int   send_gap_pct = 0;

	function automatic logic [32:0] sort_key(logic [31:0] v, logic [31:0] ref_t);
		return (v < ref_t) ? {1'b0, v} + {1'b0, sh_period} : {1'b0, v};
	endfunction

	function automatic int earliest_slot(logic [31:0] ref_t);
		int best;
		best = 0;
		for (int i = 1; i < sh_count; i++)
			if (sort_key(sh_deadline[i], ref_t) < sort_key(sh_deadline[best], ref_t))
				best = i;
		return best;
	endfunction

	function automatic logic due_window(logic [31:0] lo, logic [31:0] x, logic [31:0] hi);
		if (lo < hi)
			return x >= lo && x < hi;
		return x >= lo || x < hi;
	endfunction

	function automatic out_t predict_queue_op(in_t it);
		out_t r;
		logic [31:0] base;
		logic [31:0] dl;
		logic [32:0] sum;
		int k;
		r = '0;
		r.status = STAT_OK;
		if (it.command == CMD_SCHED || it.command == CMD_RESCHED) begin
			base = (it.command == CMD_SCHED) ? it.now_count : sh_match;
			sum = {1'b0, it.delay_ticks} + {1'b0, sh_burst};
			if (it.delay_ticks > sh_period || sum[32]) begin
				r.status = STAT_TOO_FAR;
			end else if (sh_count >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				dl = base + it.delay_ticks;
				if (dl > sh_period)
					dl = dl - sh_period;
				sh_deadline[sh_count] = dl;
				sh_tag[sh_count] = it.task_tag;
				sh_count++;
				sh_match = sh_deadline[earliest_slot(base)];
			end
		end else if (sh_count == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			if (it.command == CMD_DISP_FIRST)
				sh_burst = sh_match;
			k = earliest_slot(sh_burst);
			r.task_valid = 1'b1;
			r.dispatched_tag = sh_tag[k];
			for (int i = k; i + 1 < sh_count; i++) begin
				sh_deadline[i] = sh_deadline[i + 1];
				sh_tag[i] = sh_tag[i + 1];
			end
			sh_count--;
			if (sh_count > 0) begin
				sh_match = sh_deadline[earliest_slot(sh_burst)];
				r.more_due = due_window(sh_burst, sh_match, it.now_count);
			end
			if (!r.more_due)
				sh_burst = '0;
		end
		r.match_value = sh_match;
		return r;
	endfunction

	// Check each result strobe against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp);
			end else begin
				out_t exp_r;
				exp_r = pending_results.pop_front();
				if (rsp.status !== exp_r.status || rsp.task_valid !== exp_r.task_valid
					|| rsp.dispatched_tag !== exp_r.dispatched_tag
					|| rsp.more_due !== exp_r.more_due
					|| rsp.match_value !== exp_r.match_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", exp_r, rsp);
				end
			end
		end
	end

	// Watchdog: count cycles with no accepted item, config write or result
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > MAX_IDLE) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Send one item, predicting its result at acceptance; the next call or a
	// pause drops start, so start holds only until the next item replaces it
	task automatic send_item(cmd_t c, logic [31:0] dly, logic [15:0] tg, logic [31:0] nw);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{command: c, delay_ticks: dly, task_tag: tg, now_count: nw};
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_queue_op(req));
	endtask

	// Hold until every result has come and the block is quiet, then write the period
	task automatic write_period(logic [31:0] p);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4 * DEPTH + 10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do
			@(posedge clk);
		while (!cfg_ready);
		sh_period = p;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed;
		send_item(CMD_DISP_FIRST, 0, 0, 0);
		send_item(CMD_DISP_NEXT, 0, 0, 0);
		send_item(CMD_SCHED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(CMD_SCHED, 0, 16'h0000, 0);
		send_item(CMD_RESCHED, 100, 16'h1234, 0);
		send_item(CMD_SCHED, 50, 16'hA5A5, 32'hFFFF_FFF0);
		for (int i = 0; i < 14; i++)
			send_item(CMD_SCHED, i * 3, 16'(i), 32'd10);
		send_item(CMD_SCHED, 5, 16'h7777, 0);
		send_item(CMD_DISP_FIRST, 0, 0, 32'hFFFF_FFFF);
		for (int i = 0; i < 18; i++)
			send_item(CMD_DISP_NEXT, 0, 0, 32'd40);
	endtask

	task automatic test_small_period;
		write_period(32'd1);
		send_item(CMD_SCHED, 2, 16'h1, 0);
		send_item(CMD_SCHED, 1, 16'h2, 32'hFFFF_FFFF);
		send_item(CMD_RESCHED, 0, 16'h3, 0);
		send_item(CMD_DISP_FIRST, 0, 0, 1);
		send_item(CMD_DISP_NEXT, 0, 0, 1);
		send_item(CMD_DISP_NEXT, 0, 0, 1);
		write_period(32'd0);
		send_item(CMD_SCHED, 1, 16'h4, 5);
		send_item(CMD_SCHED, 0, 16'h5, 5);
		send_item(CMD_DISP_FIRST, 0, 0, 5);
	endtask

	// Random mix of schedules, reschedules and dispatches, with random noise
	task automatic test_random(int n, logic [31:0] p);
		logic [31:0] nw;
		logic [31:0] dly;
		int r;
		write_period(p);
		nw = $urandom_range(p);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			nw = nw + $urandom_range(40);
			if (nw > p)
				nw = nw - p;
			dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(p < 200 ? p : 200);
			if (r < 35)
				send_item(CMD_SCHED, dly, 16'($urandom), ($urandom_range(19) == 0) ? $urandom : nw);
			else if (r < 55)
				send_item(CMD_RESCHED, dly, 16'($urandom), nw);
			else if (r < 70)
				send_item(CMD_DISP_FIRST, $urandom, 16'($urandom), nw);
			else
				send_item(CMD_DISP_NEXT, $urandom, 16'($urandom), nw);
		end
	endtask

	initial begin
		sh_period = 32'hFFFF_FFFF;
		sh_count = 0;
		sh_match = '0;
		sh_burst = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_period();
		send_gap_pct = 8;
		test_random(700, 32'd1000);
		// let every pending result arrive before continuing
		start <= 1'b0;
		wait (pending_results.size() == 0);
		send_gap_pct = 49;
		test_random(600, 32'hFFFF_FFFF);
		send_gap_pct = 0;
		test_random(400, 32'd300);
		test_random(300, 32'h8000_0000);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4 * DEPTH + 20) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
